### src/maze_wall_map_with_frontier_search_defines.svh
// Assertion macros shared by the maze wall map RTL.
`ifndef MAZE_WALL_MAP_WITH_FRONTIER_SEARCH_DEFINES_SVH
`define MAZE_WALL_MAP_WITH_FRONTIER_SEARCH_DEFINES_SVH

// The consequence must hold in the same cycle as the antecedent.
`define MWMFS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define MWMFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mwmfs_pkg.sv
// Types and constants of the maze wall map with frontier search.
package mwmfs_pkg;

    localparam int CFG_W      = 5;
    localparam int COORD_W    = 4;
    localparam int SIDE_RESET = 16;

    typedef enum logic [1:0] {
        OP_UPDATE   = 2'd0,
        OP_FRONTIER = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_QUERY    = 2'd3
    } op_t;

    // Cell status codes.
    localparam logic [1:0] STAT_UNKNOWN = 2'd0;
    localparam logic [1:0] STAT_FREE    = 2'd1;
    localparam logic [1:0] STAT_VISITED = 2'd2;

    // Wall bit positions; the opposite side is always two positions away.
    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    typedef struct packed {
        op_t                operation;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [3:0]         wall_bits;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] frontier_x;
        logic [COORD_W-1:0] frontier_y;
        logic [3:0]         cell_walls;
        logic [1:0]         cell_status;
        logic               wall_present;
    } rsp_t;

    // One word of the map memory.
    typedef struct packed {
        logic [1:0] status;
        logic [3:0] walls;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

endpackage

### src/mwmfs_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module mwmfs_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/maze_wall_map_with_frontier_search.sv
// Maze wall map with frontier search: top level with its sequencer and map memory.
//
// The block keeps a square map of up to MAX_SIDE x MAX_SIDE cells, each holding four
// wall bits (north, east, south, west from bit 0 up; north is toward y+1, east toward
// x+1) and a status of unknown, free or visited. The map lives in a single RAM with one
// write port and one registered read port, and every operation is a short sequence of
// read, modify and write steps on it, so the block works on one request beat at a time.
// An update writes the cell, then reads each of its four neighbors in turn and rewrites
// those in bounds (mirroring a wall or turning an unknown neighbor free); an update or
// a query on a cell out of bounds goes straight to its response. A clear sweeps the
// whole memory at one entry per cycle. A frontier search walks the active cells in row
// order and looks at the open neighbors of each known cell one by one through the
// single read port of the map, stopping at the first frontier it finds. Writing
// maze_side on the configuration channel changes the active side (values above
// MAX_SIDE saturate, zero leaves no cell in bounds) and starts the same clearing sweep
// without producing a response. After reset the block runs that sweep too, so it holds
// requests off and takes the first beat only once the sweep is done.
// The configuration channel is ready only while the block is idle, and a waiting
// configuration write holds request beats off, so the two never land in the same cycle.
// Every request beat produces exactly one response beat. A finished response sits in an
// output register, and the block returns to idle as soon as that register is free.
`include "maze_wall_map_with_frontier_search_defines.svh"

module maze_wall_map_with_frontier_search #(
    parameter int MAX_SIDE = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  mwmfs_pkg::req_t                  req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output mwmfs_pkg::rsp_t                  rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mwmfs_pkg::CFG_W-1:0]      cfg_maze_side
);

    import mwmfs_pkg::*;

    // Coordinate width inside the map, side width (must hold MAX_SIDE itself),
    // memory depth and address width, and a compare width that also covers
    // the fixed-width request coordinates.
    localparam int CW    = $clog2(MAX_SIDE);
    localparam int SW    = CW + 1;
    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CMPW  = (SW > COORD_W) ? SW : COORD_W;

    localparam logic [SW-1:0] SIDE_INIT =
        SW'((SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_CLEAR    = 10'b00_0000_0010,
        S_UPD_CTR  = 10'b00_0000_0100,
        S_UPD_NB   = 10'b00_0000_1000,
        S_QRY_RD   = 10'b00_0001_0000,
        S_QRY_DATA = 10'b00_0010_0000,
        S_SCAN_RD  = 10'b00_0100_0000,
        S_SCAN_CTR = 10'b00_1000_0000,
        S_SCAN_NB  = 10'b01_0000_0000,
        S_RESULT   = 10'b10_0000_0000
    } state_t;

    // Linear address of a cell: row-major with a fixed stride of MAX_SIDE.
    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y);
        return AW'(int'(y) * MAX_SIDE + int'(x));
    endfunction

    // Address of the neighbor on one side. Only used where that neighbor exists.
    function automatic logic [AW-1:0] nb_addr(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y,
                                              input logic [1:0]    dir);
        logic [CW-1:0] nx;
        logic [CW-1:0] ny;
        nx = x;
        ny = y;
        case (dir)
            DIR_N:   ny = y + CW'(1);
            DIR_E:   nx = x + CW'(1);
            DIR_S:   ny = y - CW'(1);
            DIR_W:   nx = x - CW'(1);
            default: nx = x;
        endcase
        return cell_addr(nx, ny);
    endfunction

    // Lowest set side of a mask; north has priority.
    function automatic logic [1:0] first_dir(input logic [3:0] mask);
        logic [1:0] dir;
        if (mask[DIR_N])
        begin
            dir = DIR_N;
        end
        else if (mask[DIR_E])
        begin
            dir = DIR_E;
        end
        else if (mask[DIR_S])
        begin
            dir = DIR_S;
        end
        else
        begin
            dir = DIR_W;
        end
        return dir;
    endfunction

    state_t          state_reg,   state_next;
    logic [SW-1:0]   side_reg,    side_next;
    logic [AW-1:0]   clr_reg,     clr_next;
    logic            clr_op_reg,  clr_op_next;
    logic            rsp_valid_reg, rsp_valid_next;
    logic [CW-1:0]   cx_reg,      cx_next;
    logic [CW-1:0]   cy_reg,      cy_next;
    logic [3:0]      wall_reg,    wall_next;
    logic [1:0]      nb_reg,      nb_next;
    logic [3:0]      pend_reg,    pend_next;
    rsp_t            res_reg,     res_next;
    rsp_t            rsp_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    cell_t           wr_cell;
    logic [CELL_W-1:0] ram_rdata;
    cell_t           rd_cell;

    logic            req_fire;
    logic            cfg_fire;
    logic            rsp_load;
    logic            req_in_bounds;
    logic [SW-1:0]   cx_ext;
    logic [SW-1:0]   cy_ext;
    logic [3:0]      nb_exists;
    logic [3:0]      cand;
    logic [1:0]      pick_c;
    logic [1:0]      pick_p;
    logic [1:0]      mirror;
    logic            last_x;
    logic            last_y;
    logic [CW-1:0]   adv_x;
    logic [CW-1:0]   adv_y;
    cell_t           upd_cell;

    mwmfs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_cell),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A configuration write is taken only while idle and keeps request beats off
    // meanwhile, so it can never swallow an accepted request.
    assign rd_cell   = ram_rdata;
    assign req_stall = (state_reg != S_IDLE) || cfg_valid;
    assign req_fire  = req_valid && !req_stall;
    assign cfg_ready = (state_reg == S_IDLE);
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign req_in_bounds = (CMPW'(req.cell_x) < CMPW'(side_reg)) &&
                           (CMPW'(req.cell_y) < CMPW'(side_reg));

    // Neighbor existence and scan stepping for the current cell.
    assign cx_ext = SW'(cx_reg);
    assign cy_ext = SW'(cy_reg);
    assign nb_exists[DIR_N] = (cy_ext + SW'(1)) < side_reg;
    assign nb_exists[DIR_E] = (cx_ext + SW'(1)) < side_reg;
    assign nb_exists[DIR_S] = (cy_reg != '0);
    assign nb_exists[DIR_W] = (cx_reg != '0);

    assign cand   = ~rd_cell.walls & nb_exists;
    assign pick_c = first_dir(cand);
    assign pick_p = first_dir(pend_reg);

    assign last_x = (cx_ext + SW'(1)) == side_reg;
    assign last_y = (cy_ext + SW'(1)) == side_reg;
    assign adv_x  = last_x ? '0 : cx_reg + CW'(1);
    assign adv_y  = last_x ? cy_reg + CW'(1) : cy_reg;

    // Neighbor rewrite during an update: mirror the wall, or free an unknown cell.
    assign mirror = nb_reg + 2'd2;
    always_comb
    begin
        upd_cell = rd_cell;
        if (wall_reg[nb_reg])
        begin
            upd_cell.walls[mirror] = 1'b1;
        end
        else if (rd_cell.status == STAT_UNKNOWN)
        begin
            upd_cell.status = STAT_FREE;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        side_next   = side_reg;
        clr_next    = clr_reg;
        clr_op_next = clr_op_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        wall_next   = wall_reg;
        nb_next     = nb_reg;
        pend_next   = pend_reg;
        res_next    = res_reg;
        rsp_load    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = cell_addr(cx_reg, cy_reg);
        wr_cell     = '0;
        ram_raddr   = cell_addr(cx_reg, cy_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    cx_next   = CW'(req.cell_x);
                    cy_next   = CW'(req.cell_y);
                    wall_next = req.wall_bits;
                    res_next  = '0;
                    unique case (req.operation)
                        OP_UPDATE:
                        begin
                            state_next = req_in_bounds ? S_UPD_CTR : S_RESULT;
                        end
                        OP_FRONTIER:
                        begin
                            cx_next    = '0;
                            cy_next    = '0;
                            state_next = (side_reg == '0) ? S_RESULT : S_SCAN_RD;
                        end
                        OP_CLEAR:
                        begin
                            clr_next    = '0;
                            clr_op_next = 1'b1;
                            state_next  = S_CLEAR;
                        end
                        OP_QUERY:
                        begin
                            if (req_in_bounds)
                            begin
                                state_next = S_QRY_RD;
                            end
                            else
                            begin
                                res_next.wall_present = 1'b1;
                                state_next            = S_RESULT;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                wr_cell   = '0;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = clr_op_reg ? S_RESULT : S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            S_UPD_CTR:
            begin
                ram_we         = 1'b1;
                wr_cell.status = STAT_VISITED;
                wr_cell.walls  = wall_reg;
                ram_raddr      = nb_addr(cx_reg, cy_reg, DIR_N);
                nb_next        = DIR_N;
                state_next     = S_UPD_NB;
            end

            S_UPD_NB:
            begin
                ram_we    = nb_exists[nb_reg];
                ram_waddr = nb_addr(cx_reg, cy_reg, nb_reg);
                wr_cell   = upd_cell;
                ram_raddr = nb_addr(cx_reg, cy_reg, nb_reg + 2'd1);
                if (nb_reg == DIR_W)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    nb_next = nb_reg + 2'd1;
                end
            end

            S_QRY_RD:
            begin
                state_next = S_QRY_DATA;
            end

            S_QRY_DATA:
            begin
                res_next.cell_walls   = rd_cell.walls;
                res_next.cell_status  = rd_cell.status;
                res_next.wall_present = |(rd_cell.walls & wall_reg);
                state_next            = S_RESULT;
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CTR;
            end

            S_SCAN_CTR:
            begin
                if ((rd_cell.status != STAT_UNKNOWN) && (cand != '0))
                begin
                    ram_raddr  = nb_addr(cx_reg, cy_reg, pick_c);
                    pend_next  = cand & ~(4'b0001 << pick_c);
                    state_next = S_SCAN_NB;
                end
                else if (last_x && last_y)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cx_next   = adv_x;
                    cy_next   = adv_y;
                    ram_raddr = cell_addr(adv_x, adv_y);
                end
            end

            S_SCAN_NB:
            begin
                if (rd_cell.status == STAT_UNKNOWN)
                begin
                    res_next.found      = 1'b1;
                    res_next.frontier_x = COORD_W'(cx_reg);
                    res_next.frontier_y = COORD_W'(cy_reg);
                    state_next          = S_RESULT;
                end
                else if (pend_reg != '0)
                begin
                    ram_raddr = nb_addr(cx_reg, cy_reg, pick_p);
                    pend_next = pend_reg & ~(4'b0001 << pick_p);
                end
                else if (last_x && last_y)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cx_next    = adv_x;
                    cy_next    = adv_y;
                    ram_raddr  = cell_addr(adv_x, adv_y);
                    state_next = S_SCAN_CTR;
                end
            end

            S_RESULT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A configuration write sets the side and restarts the clearing sweep.
        if (cfg_fire)
        begin
            if (int'(cfg_maze_side) > MAX_SIDE)
            begin
                side_next = SW'(MAX_SIDE);
            end
            else
            begin
                side_next = SW'(cfg_maze_side);
            end
            clr_next    = '0;
            clr_op_next = 1'b0;
            state_next  = S_CLEAR;
        end
    end

    assign rsp_valid_next = rsp_load || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            side_reg      <= SIDE_INIT;
            clr_reg       <= '0;
            clr_op_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            side_reg      <= side_next;
            clr_reg       <= clr_next;
            clr_op_reg    <= clr_op_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        wall_reg <= wall_next;
        nb_reg   <= nb_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
        if (rsp_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    `MWMFS_ASSERT_NEXT(a_cfg_starts_clear, clk, rst_n, cfg_valid && cfg_ready,
        state_reg == S_CLEAR, "configuration write did not start a clearing sweep")
    `MWMFS_ASSERT_NOW(a_readonly_no_write, clk, rst_n,
        state_reg == S_IDLE || state_reg == S_QRY_DATA ||
        state_reg == S_SCAN_CTR || state_reg == S_SCAN_NB,
        !ram_we, "map written during a read-only step")
    `MWMFS_ASSERT_NOW(a_scan_in_bounds, clk, rst_n, state_reg == S_SCAN_CTR,
        (cx_ext < side_reg) && (cy_ext < side_reg), "frontier scan left the active area")
    `MWMFS_ASSERT_NOW(a_rsp_from_result, clk, rst_n, $rose(rsp_valid),
        $past(state_reg == S_RESULT), "response raised outside the result step")
    `MWMFS_ASSERT_NEXT(a_result_waits, clk, rst_n,
        state_reg == S_RESULT && rsp_valid && rsp_stall,
        state_reg == S_RESULT, "finished result dropped while output was stalled")

endmodule

### sim/mwmfs_map_checker.sv
// Checker for the maze wall map: mirrors the map, predicts each response and compares it.
module mwmfs_map_checker #(
    parameter int MAX_SIDE = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  mwmfs_pkg::req_t               req,
    input  logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  mwmfs_pkg::rsp_t               rsp,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [mwmfs_pkg::CFG_W-1:0]   cfg_maze_side,
    output int                            mismatches,
    output int                            pending,
    output int                            answered,
    output int                            frontiers_hit
);

    import mwmfs_pkg::*;

    logic [3:0]       model_walls  [MAX_SIDE*MAX_SIDE];
    logic [1:0]       model_status [MAX_SIDE*MAX_SIDE];
    logic [CFG_W-1:0] model_side;
    rsp_t             answers_due [$];
    rsp_t             want;
    int               error_total;
    int               answer_count;
    int               hit_count;

    function automatic int active_side();
        return (model_side > MAX_SIDE) ? MAX_SIDE : int'(model_side);
    endfunction

    function automatic logic in_maze(input int x, input int y);
        return x >= 0 && y >= 0 && x < active_side() && y < active_side();
    endfunction

    function automatic int cell_at(input int x, input int y);
        return y * MAX_SIDE + x;
    endfunction

    function automatic void wipe_map();
        for (int i = 0; i < MAX_SIDE * MAX_SIDE; i++)
        begin
            model_walls[i]  = 4'd0;
            model_status[i] = STAT_UNKNOWN;
        end
    endfunction

    // One side of a freshly written cell: copy the wall across, or free an unknown neighbor.
    function automatic void touch_neighbor(input int nx, input int ny, input logic wall,
                                           input logic [1:0] mirror_dir);
        int i;
        if (!in_maze(nx, ny))
            return;
        i = cell_at(nx, ny);
        if (wall)
            model_walls[i][mirror_dir] = 1'b1;
        else if (model_status[i] == STAT_UNKNOWN)
            model_status[i] = STAT_FREE;
    endfunction

    function automatic logic open_toward(input int x, input int y, input logic [1:0] dir);
        int nx;
        int ny;
        nx = x;
        ny = y;
        case (dir)
            DIR_N: ny = y + 1;
            DIR_E: nx = x + 1;
            DIR_S: ny = y - 1;
            default: nx = x - 1;
        endcase
        if (!in_maze(nx, ny) || model_walls[cell_at(x, y)][dir])
            return 1'b0;
        return model_status[cell_at(nx, ny)] == STAT_UNKNOWN;
    endfunction

    // Row-major scan for the first known cell with an open side onto unexplored ground.
    function automatic logic first_frontier(output logic [3:0] fx, output logic [3:0] fy);
        fx = 4'd0;
        fy = 4'd0;
        for (int y = 0; y < active_side(); y++)
        begin
            for (int x = 0; x < active_side(); x++)
            begin
                if (model_status[cell_at(x, y)] != STAT_UNKNOWN &&
                    (open_toward(x, y, DIR_N) || open_toward(x, y, DIR_S) ||
                     open_toward(x, y, DIR_E) || open_toward(x, y, DIR_W)))
                begin
                    fx = 4'(x);
                    fy = 4'(y);
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Applies one request to the mirrored map and returns the response it must produce.
    function automatic rsp_t answer_request(input req_t r);
        rsp_t       a;
        int         x;
        int         y;
        int         i;
        logic [3:0] w;
        a = '0;
        x = int'(r.cell_x);
        y = int'(r.cell_y);
        w = r.wall_bits;
        case (r.operation)
            OP_UPDATE:
            begin
                if (in_maze(x, y))
                begin
                    i = cell_at(x, y);
                    model_walls[i]  = w;
                    model_status[i] = STAT_VISITED;
                    touch_neighbor(x, y + 1, w[DIR_N], DIR_S);
                    if (y > 0)
                        touch_neighbor(x, y - 1, w[DIR_S], DIR_N);
                    touch_neighbor(x + 1, y, w[DIR_E], DIR_W);
                    if (x > 0)
                        touch_neighbor(x - 1, y, w[DIR_W], DIR_E);
                end
            end
            OP_FRONTIER:
                a.found = first_frontier(a.frontier_x, a.frontier_y);
            OP_CLEAR:
                wipe_map();
            default:
            begin
                if (in_maze(x, y))
                begin
                    i = cell_at(x, y);
                    a.cell_walls   = model_walls[i];
                    a.cell_status  = model_status[i];
                    a.wall_present = |(model_walls[i] & w);
                end
                else
                    a.wall_present = 1'b1;
            end
        endcase
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] wanted);
        $display("response %0d: %s is %h, %h was predicted", answer_count, what, got, wanted);
        error_total++;
    endtask

    task automatic compare_field(input string what, input logic [7:0] got,
                                 input logic [7:0] wanted);
        if (got !== wanted)
            report_mismatch(what, got, wanted);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_side = CFG_W'(SIDE_RESET);
            wipe_map();
            answers_due.delete();
            error_total   = 0;
            answer_count  = 0;
            hit_count     = 0;
            mismatches    <= 0;
            pending       <= 0;
            answered      <= 0;
            frontiers_hit <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                model_side = cfg_maze_side;
                wipe_map();
            end
            // Responses are matched before this edge's request is queued, since a request
            // cannot be answered in the cycle it is taken.
            if (rsp_valid && !rsp_stall)
            begin
                answer_count++;
                if (answers_due.size() == 0)
                    report_mismatch("beat with nothing awaited", 8'(rsp), 8'd0);
                else
                begin
                    want = answers_due.pop_front();
                    if (want.found)
                        hit_count++;
                    compare_field("found", 8'(rsp.found), 8'(want.found));
                    compare_field("frontier_x", 8'(rsp.frontier_x), 8'(want.frontier_x));
                    compare_field("frontier_y", 8'(rsp.frontier_y), 8'(want.frontier_y));
                    compare_field("cell_walls", 8'(rsp.cell_walls), 8'(want.cell_walls));
                    compare_field("cell_status", 8'(rsp.cell_status), 8'(want.cell_status));
                    compare_field("wall_present", 8'(rsp.wall_present),
                                  8'(want.wall_present));
                end
            end
            if (req_valid && !req_stall)
                answers_due.push_back(answer_request(req));
            mismatches    <= error_total;
            pending       <= answers_due.size();
            answered      <= answer_count;
            frontiers_hit <= hit_count;
        end
    end

endmodule

### sim/maze_wall_map_with_frontier_search_test.sv
// Testbench top for the maze wall map: clock, reset, request and config stimulus, verdict.
module maze_wall_map_with_frontier_search_test;
    import mwmfs_pkg::*;

    localparam int MAX_SIDE = 16;
    // Long enough that the block finishes its current request, parks the answer in its
    // output register and then has to hold the next request beat off.
    localparam int HOLDOFF_CYCLES = 300;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    req_t              req_beat;
    logic              rsp_valid;
    logic              rsp_stall;
    rsp_t              rsp_beat;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_maze_side;

    int mismatches;
    int pending;
    int answered;
    int frontiers_hit;

    // Sender bookkeeping: beats left in the current burst and beats accepted so far.
    int burst_left;
    int sent_count;
    // The request side asks for a long receiver hold-off by bumping this count; the
    // receiver process serves each ask once.
    int holdoff_asks;
    int phase_sides [$];

    maze_wall_map_with_frontier_search #(
        .MAX_SIDE (MAX_SIDE)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req_beat),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp_beat),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_maze_side (cfg_maze_side)
    );

    mwmfs_map_checker #(
        .MAX_SIDE (MAX_SIDE)
    ) map_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req           (req_beat),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp           (rsp_beat),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_maze_side (cfg_maze_side),
        .mismatches    (mismatches),
        .pending       (pending),
        .answered      (answered),
        .frontiers_hit (frontiers_hit)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic req_t make_req(input op_t op, input int x, input int y, input int w);
        req_t r;
        r.operation = op;
        r.cell_x    = 4'(x);
        r.cell_y    = 4'(y);
        r.wall_bits = 4'(w);
        return r;
    endfunction

    // Random request for a map of active side s. Updates dominate so that the map fills
    // in and frontier searches meet real explored regions; clears are rare because each
    // one throws that exploration away. Coordinates mostly land inside the map, but one
    // in five spans the whole 4-bit range to hit the out-of-bounds paths.
    function automatic req_t random_request(input int s);
        req_t r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            r.operation = OP_UPDATE;
        else if (pick < 77)
            r.operation = OP_QUERY;
        else if (pick < 95)
            r.operation = OP_FRONTIER;
        else
            r.operation = OP_CLEAR;
        if (s > 0 && $urandom_range(0, 4) != 0)
            r.cell_x = 4'($urandom_range(0, s - 1));
        else
            r.cell_x = 4'($urandom_range(0, 15));
        if (s > 0 && $urandom_range(0, 4) != 0)
            r.cell_y = 4'($urandom_range(0, s - 1));
        else
            r.cell_y = 4'($urandom_range(0, 15));
        r.wall_bits = 4'($urandom_range(0, 15));
        return r;
    endfunction

    // Offers one request beat and returns at the edge that accepts it. Between bursts the
    // valid drops for a random gap; a new burst is either short or a long unbroken run.
    task automatic offer(input req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 25);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 12);
        end
        req_valid <= 1'b1;
        req_beat  <= r;
        do @(posedge clk); while (req_stall);
        burst_left--;
        sent_count++;
    endtask

    // Stops offering and waits until every predicted response has come back. The first
    // edge lets the checker's count catch up with the last accepted beat.
    task automatic wait_for_answers();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // Writes maze_side while the block is idle. Every request yields a response, so once
    // the last one is out the block is free; a few spare cycles cover the return to idle.
    task automatic write_side(input int side);
        repeat (4) @(posedge clk);
        cfg_valid     <= 1'b1;
        cfg_maze_side <= CFG_W'(side);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: stall pattern picked per window of random length. Modes are no stall at
    // all, light random stalls, heavy random stalls and a fixed duty pattern. When the
    // request side asks, the receiver holds off for a long counted stretch instead.
    initial
    begin
        int window;
        int mode;
        int holdoffs_done;
        int tick;
        logic hold;
        holdoffs_done = 0;
        tick = 0;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            window = $urandom_range(20, 200);
            mode   = $urandom_range(0, 3);
            repeat (window)
            begin
                @(posedge clk);
                tick++;
                if (holdoff_asks != holdoffs_done)
                begin
                    rsp_stall <= 1'b1;
                    repeat (HOLDOFF_CYCLES) @(posedge clk);
                    holdoffs_done++;
                end
                case (mode)
                    0: hold = 1'b0;
                    1: hold = ($urandom_range(0, 3) == 0);
                    2: hold = ($urandom_range(0, 3) != 0);
                    default: hold = ((tick % 8) < 3);
                endcase
                rsp_stall <= hold;
            end
        end
    end

    // Watchdog: far beyond the slowest legal run of this stimulus, even with every
    // request a full-size frontier search behind the longest receiver stalls.
    initial
    begin
        #160000000;
        $display("maze_wall_map_with_frontier_search_test failed");
        $finish;
    end

    initial
    begin
        int side;
        int active;
        int items;
        int drain_cycles;
        req_valid     <= 1'b0;
        req_beat      <= '0;
        cfg_valid     <= 1'b0;
        cfg_maze_side <= '0;
        holdoff_asks  <= 0;
        burst_left    = 0;
        sent_count    = 0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset side of 16. The block sweeps its map after reset and
        // stalls requests meanwhile; the first beat simply waits for that.
        // An empty map: unknown cell, no frontier.
        offer(make_req(OP_QUERY, 0, 0, 15));
        offer(make_req(OP_FRONTIER, 0, 0, 0));
        // Open corner cell frees its two neighbors; the scan then finds a frontier.
        offer(make_req(OP_UPDATE, 0, 0, 0));
        offer(make_req(OP_FRONTIER, 0, 0, 0));
        offer(make_req(OP_QUERY, 1, 0, 15));
        // Far corner fully walled: walls mirror into the two in-bounds neighbors only.
        offer(make_req(OP_UPDATE, 15, 15, 15));
        offer(make_req(OP_QUERY, 15, 14, 1));
        offer(make_req(OP_QUERY, 14, 15, 2));
        // Two adjacent cells; the west wall of the second mirrors into the east side of the first.
        offer(make_req(OP_UPDATE, 5, 7, 5));
        offer(make_req(OP_UPDATE, 6, 7, 10));
        offer(make_req(OP_QUERY, 5, 7, 2));
        offer(make_req(OP_QUERY, 6, 7, 15));
        offer(make_req(OP_FRONTIER, 0, 0, 0));
        // Edge cells whose walls point off the map.
        offer(make_req(OP_UPDATE, 15, 0, 6));
        offer(make_req(OP_UPDATE, 0, 15, 9));
        offer(make_req(OP_QUERY, 15, 0, 4));
        // Clear, then a walled-in cell that is visited but is no frontier.
        offer(make_req(OP_CLEAR, 0, 0, 0));
        offer(make_req(OP_QUERY, 15, 15, 15));
        offer(make_req(OP_FRONTIER, 0, 0, 0));
        offer(make_req(OP_UPDATE, 8, 8, 15));
        offer(make_req(OP_FRONTIER, 0, 0, 0));
        offer(make_req(OP_UPDATE, 8, 9, 0));
        offer(make_req(OP_FRONTIER, 0, 0, 0));
        offer(make_req(OP_QUERY, 8, 8, 1));

        // Random phases, one per map side. Zero leaves no cell in bounds, 31 and 17
        // saturate to the full map. Big maps get fewer requests since every frontier
        // search and clear on them can walk the whole map.
        phase_sides = '{1, 0, 31, 2, 3, 4, 16, 5, 6, 7, 8, 17, 2, 3, 4, 10, 12, 5, 3, 6};
        foreach (phase_sides[p])
        begin
            side   = phase_sides[p];
            active = (side > MAX_SIDE) ? MAX_SIDE : side;
            items  = (active >= 10) ? 40 : 78;
            wait_for_answers();
            write_side(side);
            if (p == 4 || p == 12)
                holdoff_asks <= holdoff_asks + 1;
            repeat (items) offer(random_request(active));
        end
        req_valid <= 1'b0;

        // Let the last responses drain, then a little more for any stray beat. The first
        // edge lets the checker's count catch up with the last accepted beat.
        drain_cycles = 0;
        do
        begin
            @(posedge clk);
            drain_cycles++;
        end
        while (pending != 0 && drain_cycles < 50000);
        repeat (20) @(posedge clk);

        $display("Sent %0d requests over %0d map sides (0, 1, full and saturating included),",
                 sent_count, phase_sides.size() + 1);
        $display("checked %0d responses; %0d frontier searches found a cell.",
                 answered, frontiers_hit);
        if (mismatches == 0 && pending == 0)
            $display("maze_wall_map_with_frontier_search_test passed");
        else
            $display("maze_wall_map_with_frontier_search_test failed");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/mwmfs_pkg.sv
src/mwmfs_ram.sv
src/maze_wall_map_with_frontier_search.sv
sim/mwmfs_map_checker.sv
sim/maze_wall_map_with_frontier_search_test.sv
